>>> rtl/core/srd_pkg.sv
// Shared types and constants for the sprite run-length decoder.
// No dependencies; imported by every module in rtl/core.
package srd_pkg;

    // Input beat: one byte of run-length pixel data
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    // Output beat: one pixel write and/or a frame end marker
    typedef struct packed {
        logic       pixel_valid;
        logic [9:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_out_beat;

    // Width of the pixel index carried on the output
    localparam int unsigned PIX_IDX_W = 10;

    // Byte queue between front and back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;
    localparam int unsigned Q_CW    = 3;

endpackage

>>> rtl/core/srd_queue.sv
// Front end of the sprite decoder: accepts byte beats into a short queue.
// Depends on srd_pkg for the beat type and queue sizing.
module srd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  srd_pkg::t_in_beat i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output srd_pkg::t_in_beat o_pop_data
);
    import srd_pkg::*;

    t_in_beat          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_CW-1:0]   r_count;
    logic [Q_AW-1:0]   n_wr_ptr;
    logic [Q_AW-1:0]   n_rd_ptr;
    logic [Q_CW-1:0]   n_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != Q_CW'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = i_pop && o_pop_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Occupancy stays within the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue occupancy beyond depth");

    // A push into an empty queue makes it non-empty next cycle
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && (r_count == '0)) |=> o_pop_valid)
        else $error("pushed beat not visible");

    // Pointer distance tracks occupancy
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[Q_AW-1:0])
        else $error("queue pointers disagree with count");

endmodule

>>> rtl/core/srd_exec.sv
// Back end of the sprite decoder: walks the run-length fields and
// registers pixel writes and frame ends. Depends on srd_pkg.
module srd_exec #(
    parameter int unsigned IMAGE_PIXELS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_beat_valid,
    output logic              o_beat_pop,
    input  srd_pkg::t_in_beat i_beat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output srd_pkg::t_out_beat o_out_data
);
    import srd_pkg::*;

    localparam int unsigned POS_W = $clog2(IMAGE_PIXELS + 1);
    localparam int unsigned SUM_W = ((POS_W > 16) ? POS_W : 16) + 1;
    localparam logic [POS_W-1:0] IMG_END = POS_W'(IMAGE_PIXELS);

    typedef enum logic [2:0] {
        PH_TLO = 3'd0,
        PH_THI = 3'd1,
        PH_CLO = 3'd2,
        PH_CHI = 3'd3,
        PH_RED = 3'd4,
        PH_GRN = 3'd5,
        PH_BLU = 3'd6
    } t_phase;

    t_phase            r_phase,     n_phase;
    logic [7:0]        r_count_low, n_count_low;
    logic [15:0]       r_colored,   n_colored;
    logic [POS_W-1:0]  r_pos,       n_pos;
    logic [7:0]        r_red,       n_red;
    logic [7:0]        r_green,     n_green;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out,       n_out;

    logic              pop;
    logic              active;
    logic              wrote;
    logic [15:0]       beat_count;
    logic [SUM_W-1:0]  skip_sum;
    logic [15:0]       colored_dec;
    logic [POS_W+PIX_IDX_W-1:0] pos_ext;

    assign pop        = i_beat_valid && (!r_out_valid || i_out_ready);
    assign o_beat_pop = pop;
    assign active     = (r_pos < IMG_END);
    assign beat_count = {i_beat.data_byte, r_count_low};
    assign skip_sum   = SUM_W'(r_pos) + SUM_W'(beat_count);
    assign colored_dec = r_colored - 16'd1;
    assign pos_ext    = {{PIX_IDX_W{1'b0}}, r_pos};

    // Decode the beat against the current field
    always_comb begin
        n_phase     = r_phase;
        n_count_low = r_count_low;
        n_colored   = r_colored;
        n_pos       = r_pos;
        n_red       = r_red;
        n_green     = r_green;
        wrote       = 1'b0;

        if (pop && active) begin
            case (r_phase)
                PH_THI: begin
                    // Saturate the skip at the image end
                    if (skip_sum > SUM_W'(IMAGE_PIXELS)) begin
                        n_pos = IMG_END;
                    end else begin
                        n_pos = skip_sum[POS_W-1:0];
                    end
                    n_phase = PH_CLO;
                end
                PH_CLO: begin
                    n_count_low = i_beat.data_byte;
                    n_phase     = PH_CHI;
                end
                PH_CHI: begin
                    n_colored = beat_count;
                    n_phase   = (beat_count != 16'd0) ? PH_RED : PH_TLO;
                end
                PH_RED: begin
                    n_red   = i_beat.data_byte;
                    n_phase = PH_GRN;
                end
                PH_GRN: begin
                    n_green = i_beat.data_byte;
                    n_phase = PH_BLU;
                end
                PH_BLU: begin
                    wrote     = 1'b1;
                    n_pos     = r_pos + 1'b1;
                    n_colored = colored_dec;
                    n_phase   = (colored_dec != 16'd0) ? PH_RED : PH_TLO;
                end
                default: begin
                    n_count_low = i_beat.data_byte;
                    n_phase     = PH_THI;
                end
            endcase
        end

        // Drop partial fields at the end of the sprite
        if (pop && i_beat.last_byte) begin
            n_phase     = PH_TLO;
            n_count_low = '0;
            n_colored   = '0;
            n_pos       = '0;
            n_red       = '0;
            n_green     = '0;
        end
    end

    // Load or drain the output register
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (pop && (wrote || i_beat.last_byte)) begin
            n_out_valid       = 1'b1;
            n_out.pixel_valid = wrote;
            n_out.pixel_index = wrote ? pos_ext[PIX_IDX_W-1:0] : '0;
            n_out.red         = wrote ? r_red : '0;
            n_out.green       = wrote ? r_green : '0;
            n_out.blue        = wrote ? i_beat.data_byte : '0;
            n_out.frame_end   = i_beat.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TLO;
            r_count_low <= '0;
            r_colored   <= '0;
            r_pos       <= '0;
            r_red       <= '0;
            r_green     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count_low <= n_count_low;
            r_colored   <= n_colored;
            r_pos       <= n_pos;
            r_red       <= n_red;
            r_green     <= n_green;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Position never passes the image end
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= IMG_END)
        else $error("write position beyond image");

    // A last beat returns the decoder to the start of a sprite
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_beat.last_byte) |=> ((r_phase == PH_TLO) && (r_pos == '0)))
        else $error("state not cleared after last beat");

    // A colored phase always has triples left
    a_colored_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_RED) || (r_phase == PH_GRN) || (r_phase == PH_BLU))
        |-> (r_colored != 16'd0))
        else $error("colored phase with empty run");

    // Never pop while a held result is stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !pop)
        else $error("result overwritten while stalled");

endmodule

>>> rtl/core/sprite_rle_decoder.sv
// Top level of the sprite run-length decoder: byte queue feeding the
// field decoder. Depends on srd_pkg, srd_queue and srd_exec.
//
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+--------------------------
//  in      | input     | t_in_beat  (9 bits)  | i_in_valid / o_in_ready
//  out     | output    | t_out_beat (36 bits) | o_out_valid / i_out_ready
//
// One byte beat per cycle sustained while out is not stalled; a result passes
// through a queue slot, then the output register, before it is valid on out.
// The four-entry byte queue keeps accepting, until full, while a result waits on out.
// A stalled out channel holds its result and the decoder stops popping.
// Reset is synchronous, active low, and clears queue and decoder state.
module sprite_rle_decoder #(
    parameter int unsigned IMAGE_PIXELS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  srd_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output srd_pkg::t_out_beat o_out_data
);
    import srd_pkg::*;

    logic     q_valid;
    logic     q_pop;
    t_in_beat q_data;

    // Front: accept beats
    srd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in_valid),
        .o_push_ready (o_in_ready),
        .i_push_data  (i_in_data),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_data   (q_data)
    );

    // Back: decode fields and emit pixels
    srd_exec #(
        .IMAGE_PIXELS (IMAGE_PIXELS)
    ) u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (q_valid),
        .o_beat_pop   (q_pop),
        .i_beat       (q_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule
